[rtl/core/pool2d_pkg.sv]
// ----------------------------------------------------------------------------
// pool2d_pkg
// Shared types and constants for the two-dimensional pooling block: plane
// geometry, data and accumulator widths, register map, modes and states.
// ----------------------------------------------------------------------------
package pool2d_pkg;

    // plane and window geometry
    localparam int MAX_DIM    = 64;
    localparam int MAX_WINDOW = 16;
    localparam int DATA_WIDTH = 16;

    localparam int DIM_W      = $clog2(MAX_DIM);
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W     = 2 * DIM_W;

    // configuration register widths
    localparam int MODE_REG_W = 2;
    localparam int WIN_REG_W  = 5;
    localparam int IMG_REG_W  = 7;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 3;

    // derived datapath widths
    localparam int POS_W  = DIM_W + WIN_REG_W;
    localparam int CNT_W  = 2 * $clog2(MAX_WINDOW) + 1;
    localparam int SUM_W  = DATA_WIDTH + 2 * $clog2(MAX_WINDOW);
    localparam int IDX_W  = 12;
    localparam int OFF_W  = DIM_W + IMG_REG_W;
    localparam int BIT_W  = $clog2(SUM_W);

    // most negative sample, reported by an empty max window
    localparam logic [DATA_WIDTH-1:0] DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POOL_MODE     = 3'd0,
        CFG_WINDOW_WIDTH  = 3'd1,
        CFG_WINDOW_HEIGHT = 3'd2,
        CFG_STRIDE_X      = 3'd3,
        CFG_STRIDE_Y      = 3'd4,
        CFG_IMAGE_WIDTH   = 3'd5,
        CFG_IMAGE_HEIGHT  = 3'd6
    } t_cfg_reg;

    // pooling modes, upper codes select max
    typedef enum logic [MODE_REG_W-1:0] {
        MODE_AVG_FULL  = 2'd0,
        MODE_AVG_VALID = 2'd1,
        MODE_MAX       = 2'd2
    } t_pool_mode;

    // transaction opcodes
    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_COMPUTE = 1'b1
    } t_op;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_WALK,
        S_DRAIN,
        S_FINISH,
        S_DIV,
        S_OUT
    } t_state;

endpackage

[rtl/core/pool2d_ram.sv]
// ----------------------------------------------------------------------------
// pool2d_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module pool2d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/pooling_2d_forward.sv]
// ----------------------------------------------------------------------------
// Timing: a load writes the plane RAM directly. A compute walks the in-bounds
// window pixels (1 to 256), one pixel per cycle from the plane RAM, then in the
// average modes divides with one quotient bit per cycle over a 24-bit sum; an
// empty window skips both. The input is stalled until the result is registered,
// and a stalled output register that is still full holds the result back.
// Reset: synchronous, active low; clears control and config, not the plane.
// ----------------------------------------------------------------------------
// pooling_2d_forward
// Max / average pooling over one stored image plane: load transactions fill
// the plane, compute transactions walk one clipped window and return a result.
// ----------------------------------------------------------------------------
module pooling_2d_forward (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write port
    input  logic                                 i_cfg_we,
    input  logic [pool2d_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pool2d_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_op,
    input  logic [pool2d_pkg::DIM_W-1:0]         i_col,
    input  logic [pool2d_pkg::DIM_W-1:0]         i_row,
    input  logic signed [pool2d_pkg::DATA_WIDTH-1:0] i_pixel_value,
    // output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [pool2d_pkg::DATA_WIDTH-1:0] o_pooled_value,
    output logic [pool2d_pkg::IDX_W-1:0]         o_max_index,
    output logic                                 o_empty_window
);

    localparam int DW  = pool2d_pkg::DATA_WIDTH;
    localparam int DMW = pool2d_pkg::DIM_W;
    localparam int WRW = pool2d_pkg::WIN_REG_W;
    localparam int IRW = pool2d_pkg::IMG_REG_W;
    localparam int PW  = pool2d_pkg::POS_W;
    localparam int CW  = pool2d_pkg::CNT_W;
    localparam int SW  = pool2d_pkg::SUM_W;
    localparam int XW  = pool2d_pkg::IDX_W;
    localparam int OW  = pool2d_pkg::OFF_W;
    localparam int BW  = pool2d_pkg::BIT_W;

    // configuration registers
    logic [pool2d_pkg::MODE_REG_W-1:0] r_mode;
    logic [WRW-1:0] r_win_w, r_win_h, r_str_x, r_str_y;
    logic [IRW-1:0] r_img_w, r_img_h;

    // saturated geometry
    logic [IRW-1:0] iw_sat, ih_sat;
    logic [WRW-1:0] ww_sat, wh_sat;
    logic           is_max;

    // sequencer
    pool2d_pkg::t_state r_state, n_state;

    // walk state
    logic [DMW-1:0] r_col, n_col, r_row, n_row;
    logic [DMW-1:0] r_x, n_x, r_y, n_y, r_y0, n_y0;
    logic [IRW-1:0] r_x1, n_x1, r_y1, n_y1;
    logic           r_rd_vld, n_rd_vld;
    logic [XW-1:0]  r_rd_idx, n_rd_idx;

    // accumulators
    logic signed [SW-1:0] r_sum, n_sum;
    logic signed [DW-1:0] r_best, n_best;
    logic [XW-1:0]  r_best_idx, n_best_idx;
    logic [CW-1:0]  r_count, n_count;

    // divider
    logic [SW-1:0]  r_quo, n_quo;
    logic [CW-1:0]  r_rem, n_rem, r_div, n_div;
    logic [BW-1:0]  r_bit, n_bit;
    logic           r_neg, n_neg;

    // pending result and output register
    logic signed [DW-1:0] r_res_value, n_res_value;
    logic [XW-1:0]  r_res_idx, n_res_idx;
    logic           r_res_empty, n_res_empty;
    logic           r_out_vld, n_out_vld;
    logic signed [DW-1:0] r_out_value, n_out_value;
    logic [XW-1:0]  r_out_idx, n_out_idx;
    logic           r_out_empty, n_out_empty;

    // combinational helpers
    logic           in_accept;
    logic [PW-1:0]  x0, y0;
    logic [PW:0]    x_end, y_end;
    logic [IRW-1:0] x1, y1;
    logic           win_empty;
    logic [OW-1:0]  row_off;
    logic [IRW-1:0] x_inc, y_inc;
    logic signed [DW-1:0] rd_data;
    logic [SW-1:0]  mag;
    logic [CW:0]    shifted;
    logic [SW-1:0]  quo_next;
    logic [SW-1:0]  quo_signed;
    logic [2*WRW-1:0] area;

    logic [pool2d_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
    logic           ram_we;

    assign in_accept = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != pool2d_pkg::S_IDLE);

    // plane store
    assign ram_we    = in_accept && (i_op == pool2d_pkg::OP_LOAD);
    assign ram_waddr = {i_row, i_col};
    assign ram_raddr = {r_y, r_x};

    pool2d_ram #(
        .WIDTH (DW),
        .DEPTH (pool2d_pkg::STORE_DEPTH)
    ) u_plane (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_pixel_value),
        .i_raddr (ram_raddr),
        .o_rdata (rd_data)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= pool2d_pkg::MODE_MAX;
            r_win_w <= WRW'(2);
            r_win_h <= WRW'(2);
            r_str_x <= WRW'(2);
            r_str_y <= WRW'(2);
            r_img_w <= IRW'(pool2d_pkg::MAX_DIM);
            r_img_h <= IRW'(pool2d_pkg::MAX_DIM);
        end else if (i_cfg_we) begin
            case (pool2d_pkg::t_cfg_reg'(i_cfg_index))
                pool2d_pkg::CFG_POOL_MODE:     r_mode  <= i_cfg_data[1:0];
                pool2d_pkg::CFG_WINDOW_WIDTH:  r_win_w <= i_cfg_data[WRW-1:0];
                pool2d_pkg::CFG_WINDOW_HEIGHT: r_win_h <= i_cfg_data[WRW-1:0];
                pool2d_pkg::CFG_STRIDE_X:      r_str_x <= i_cfg_data[WRW-1:0];
                pool2d_pkg::CFG_STRIDE_Y:      r_str_y <= i_cfg_data[WRW-1:0];
                pool2d_pkg::CFG_IMAGE_WIDTH:   r_img_w <= i_cfg_data[IRW-1:0];
                pool2d_pkg::CFG_IMAGE_HEIGHT:  r_img_h <= i_cfg_data[IRW-1:0];
                default: ;
            endcase
        end
    end

    // saturate geometry to the plane and window limits
    assign iw_sat = (r_img_w > IRW'(pool2d_pkg::MAX_DIM)) ? IRW'(pool2d_pkg::MAX_DIM) : r_img_w;
    assign ih_sat = (r_img_h > IRW'(pool2d_pkg::MAX_DIM)) ? IRW'(pool2d_pkg::MAX_DIM) : r_img_h;
    assign ww_sat = (r_win_w > WRW'(pool2d_pkg::MAX_WINDOW))
                  ? WRW'(pool2d_pkg::MAX_WINDOW) : r_win_w;
    assign wh_sat = (r_win_h > WRW'(pool2d_pkg::MAX_WINDOW))
                  ? WRW'(pool2d_pkg::MAX_WINDOW) : r_win_h;
    assign is_max = r_mode[1];

    // window corners, clipped at the right and bottom edge
    assign x0    = PW'(r_col) * PW'(r_str_x);
    assign y0    = PW'(r_row) * PW'(r_str_y);
    assign x_end = (PW+1)'(x0) + (PW+1)'(ww_sat);
    assign y_end = (PW+1)'(y0) + (PW+1)'(wh_sat);
    assign x1    = (x_end > (PW+1)'(iw_sat)) ? iw_sat : x_end[IRW-1:0];
    assign y1    = (y_end > (PW+1)'(ih_sat)) ? ih_sat : y_end[IRW-1:0];
    assign win_empty = (x0 >= PW'(x1)) || (y0 >= PW'(y1));

    // in-plane index of the pixel being read
    assign row_off = OW'(r_y) * OW'(iw_sat);
    assign x_inc   = IRW'(r_x) + IRW'(1);
    assign y_inc   = IRW'(r_y) + IRW'(1);

    // divider step and final sign
    assign mag        = r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);
    assign shifted    = {r_rem, r_quo[SW-1]};
    assign quo_next   = {r_quo[SW-2:0], (shifted >= {1'b0, r_div})};
    assign quo_signed = r_neg ? SW'(-quo_next) : quo_next;
    assign area       = (2*WRW)'(ww_sat) * (2*WRW)'(wh_sat);

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pool2d_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and datapath
    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_x         = r_x;
        n_y         = r_y;
        n_y0        = r_y0;
        n_x1        = r_x1;
        n_y1        = r_y1;
        n_rd_vld    = 1'b0;
        n_rd_idx    = r_rd_idx;
        n_sum       = r_sum;
        n_best      = r_best;
        n_best_idx  = r_best_idx;
        n_count     = r_count;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_div       = r_div;
        n_bit       = r_bit;
        n_neg       = r_neg;
        n_res_value = r_res_value;
        n_res_idx   = r_res_idx;
        n_res_empty = r_res_empty;
        n_out_vld   = r_out_vld && i_out_stall;
        n_out_value = r_out_value;
        n_out_idx   = r_out_idx;
        n_out_empty = r_out_empty;

        // fold in the pixel read last cycle
        if (r_rd_vld) begin
            n_sum   = r_sum + {{(SW-DW){rd_data[DW-1]}}, rd_data};
            n_count = r_count + CW'(1);
            if (r_count == '0 || rd_data > r_best) begin
                n_best     = rd_data;
                n_best_idx = r_rd_idx;
            end
        end

        case (r_state)
            pool2d_pkg::S_IDLE: begin
                if (in_accept && i_op == pool2d_pkg::OP_COMPUTE) begin
                    n_col   = i_col;
                    n_row   = i_row;
                    n_state = pool2d_pkg::S_SETUP;
                end
            end

            pool2d_pkg::S_SETUP: begin
                n_sum   = '0;
                n_count = '0;
                n_x     = x0[DMW-1:0];
                n_y     = y0[DMW-1:0];
                n_y0    = y0[DMW-1:0];
                n_x1    = x1;
                n_y1    = y1;
                if (win_empty) begin
                    n_res_value = is_max ? pool2d_pkg::DATA_MIN : '0;
                    n_res_idx   = '0;
                    n_res_empty = 1'b1;
                    n_state     = pool2d_pkg::S_OUT;
                end else begin
                    n_state = pool2d_pkg::S_WALK;
                end
            end

            // one read per cycle, column outer and row inner
            pool2d_pkg::S_WALK: begin
                n_rd_vld = 1'b1;
                n_rd_idx = XW'(row_off + OW'(r_x));
                if (y_inc == r_y1) begin
                    n_y = r_y0;
                    n_x = x_inc[DMW-1:0];
                    if (x_inc == r_x1) begin
                        n_state = pool2d_pkg::S_DRAIN;
                    end
                end else begin
                    n_y = y_inc[DMW-1:0];
                end
            end

            pool2d_pkg::S_DRAIN: begin
                n_state = pool2d_pkg::S_FINISH;
            end

            pool2d_pkg::S_FINISH: begin
                n_res_empty = 1'b0;
                if (is_max) begin
                    n_res_value = r_best;
                    n_res_idx   = r_best_idx;
                    n_state     = pool2d_pkg::S_OUT;
                end else begin
                    n_res_idx = '0;
                    n_neg     = r_sum[SW-1];
                    n_quo     = mag;
                    n_rem     = '0;
                    n_div     = (r_mode == pool2d_pkg::MODE_AVG_FULL) ? CW'(area) : r_count;
                    n_bit     = BW'(SW - 1);
                    n_state   = pool2d_pkg::S_DIV;
                end
            end

            // restoring division, one quotient bit per cycle
            pool2d_pkg::S_DIV: begin
                n_quo = quo_next;
                n_rem = (shifted >= {1'b0, r_div}) ? CW'(shifted - {1'b0, r_div})
                                                   : shifted[CW-1:0];
                n_bit = r_bit - BW'(1);
                if (r_bit == '0) begin
                    n_res_value = quo_signed[DW-1:0];
                    n_state     = pool2d_pkg::S_OUT;
                end
            end

            // hand over once the output register is free
            pool2d_pkg::S_OUT: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_out_vld   = 1'b1;
                    n_out_value = r_res_value;
                    n_out_idx   = r_res_idx;
                    n_out_empty = r_res_empty;
                    n_state     = pool2d_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = pool2d_pkg::S_IDLE;
            end
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
        r_col       <= n_col;
        r_row       <= n_row;
        r_x         <= n_x;
        r_y         <= n_y;
        r_y0        <= n_y0;
        r_x1        <= n_x1;
        r_y1        <= n_y1;
        r_rd_idx    <= n_rd_idx;
        r_sum       <= n_sum;
        r_best      <= n_best;
        r_best_idx  <= n_best_idx;
        r_count     <= n_count;
        r_quo       <= n_quo;
        r_rem       <= n_rem;
        r_div       <= n_div;
        r_bit       <= n_bit;
        r_neg       <= n_neg;
        r_res_value <= n_res_value;
        r_res_idx   <= n_res_idx;
        r_res_empty <= n_res_empty;
        r_out_value <= n_out_value;
        r_out_idx   <= n_out_idx;
        r_out_empty <= n_out_empty;
    end

    assign o_out_valid    = r_out_vld;
    assign o_pooled_value = r_out_value;
    assign o_max_index    = r_out_idx;
    assign o_empty_window = r_out_empty;

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for pooling_2d_forward. Load and compute transactions
// come from a queue that the main sequence fills one register setting at a
// time. A shadow plane and shadow registers predict each pooled result,
// which the monitor checks field by field against the output channel.
// ----------------------------------------------------------------------------
module testbench;

    localparam int DW  = pool2d_pkg::DATA_WIDTH;
    localparam int DMW = pool2d_pkg::DIM_W;
    localparam int XW  = pool2d_pkg::IDX_W;
    localparam int MRW = pool2d_pkg::MODE_REG_W;
    localparam int WRW = pool2d_pkg::WIN_REG_W;
    localparam int IRW = pool2d_pkg::IMG_REG_W;
    localparam int CIW = pool2d_pkg::CFG_IDX_W;
    localparam int CDW = pool2d_pkg::CFG_DATA_W;

    // spare mode code, decodes as max
    localparam logic [MRW-1:0] MODE_SPARE = 2'd3;
    // least number of transactions queued over the whole run, loads included
    localparam int ITEM_TARGET = 1250;

    typedef struct {
        pool2d_pkg::t_op      op;
        logic [DMW-1:0]       col;
        logic [DMW-1:0]       row;
        logic signed [DW-1:0] pixel;
    } t_pixel_req;

    typedef struct {
        logic signed [DW-1:0] value;
        logic [XW-1:0]        index;
        logic                 empty;
    } t_pooled;

    // dut connections, inputs all known from time zero
    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_we       = 1'b0;
    logic [CIW-1:0]       i_cfg_index    = '0;
    logic [CDW-1:0]       i_cfg_data     = '0;
    logic                 i_in_valid     = 1'b0;
    logic                 o_in_stall;
    logic                 i_op           = pool2d_pkg::OP_LOAD;
    logic [DMW-1:0]       i_col          = '0;
    logic [DMW-1:0]       i_row          = '0;
    logic signed [DW-1:0] i_pixel_value  = '0;
    logic                 o_out_valid;
    logic                 i_out_stall    = 1'b0;
    logic signed [DW-1:0] o_pooled_value;
    logic [XW-1:0]        o_max_index;
    logic                 o_empty_window;

    // shadow registers at their reset values
    logic [MRW-1:0] cfg_mode = pool2d_pkg::MODE_MAX;
    logic [WRW-1:0] cfg_ww   = 5'd2;
    logic [WRW-1:0] cfg_wh   = 5'd2;
    logic [WRW-1:0] cfg_sx   = 5'd2;
    logic [WRW-1:0] cfg_sy   = 5'd2;
    logic [IRW-1:0] cfg_iw   = 7'd64;
    logic [IRW-1:0] cfg_ih   = 7'd64;

    // shadow plane and the entries already scheduled for a load
    logic signed [DW-1:0] plane [pool2d_pkg::STORE_DEPTH];
    bit                   planned [pool2d_pkg::STORE_DEPTH];

    t_pixel_req pending_reqs [$];
    t_pooled    expected_pools [$];
    t_pixel_req next_req;
    t_pooled    want;

    bit in_fired   = 1'b0;
    int burst_left = 0;
    int gap_left   = 0;
    int gap_max    = 0;
    int stall_pct  = 0;
    int fail_count = 0;
    int queued     = 0;

    pooling_2d_forward dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_col          (i_col),
        .i_row          (i_row),
        .i_pixel_value  (i_pixel_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_pooled_value (o_pooled_value),
        .o_max_index    (o_max_index),
        .o_empty_window (o_empty_window)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // clipped window bounds under the current register values
    function automatic void window_span(input logic [DMW-1:0] col, row,
                                        output int x0, x1, y0, y1, iw);
        int ih, ww, wh;
        iw = (int'(cfg_iw) > pool2d_pkg::MAX_DIM) ? pool2d_pkg::MAX_DIM : int'(cfg_iw);
        ih = (int'(cfg_ih) > pool2d_pkg::MAX_DIM) ? pool2d_pkg::MAX_DIM : int'(cfg_ih);
        ww = (int'(cfg_ww) > pool2d_pkg::MAX_WINDOW) ? pool2d_pkg::MAX_WINDOW : int'(cfg_ww);
        wh = (int'(cfg_wh) > pool2d_pkg::MAX_WINDOW) ? pool2d_pkg::MAX_WINDOW : int'(cfg_wh);
        x0 = int'(col) * int'(cfg_sx);
        y0 = int'(row) * int'(cfg_sy);
        x1 = (x0 + ww > iw) ? iw : x0 + ww;
        y1 = (y0 + wh > ih) ? ih : y0 + wh;
    endfunction

    // pooled result of one output position over the shadow plane
    function automatic t_pooled pool_window(input logic [DMW-1:0] col, row);
        int x0, x1, y0, y1, iw, x, y, v, cnt, sum, best, best_at, div, ww, wh, q;
        t_pooled r;
        window_span(col, row, x0, x1, y0, y1, iw);
        ww = (int'(cfg_ww) > pool2d_pkg::MAX_WINDOW) ? pool2d_pkg::MAX_WINDOW : int'(cfg_ww);
        wh = (int'(cfg_wh) > pool2d_pkg::MAX_WINDOW) ? pool2d_pkg::MAX_WINDOW : int'(cfg_wh);
        cnt = 0;
        sum = 0;
        best = 0;
        best_at = 0;
        // column outer, row inner; only a strictly greater pixel replaces
        for (x = x0; x < x1; x++) begin
            for (y = y0; y < y1; y++) begin
                v = int'(plane[y * pool2d_pkg::MAX_DIM + x]);
                if (cnt == 0 || v > best) begin
                    best = v;
                    best_at = x + y * iw;
                end
                sum += v;
                cnt++;
            end
        end
        r.index = '0;
        r.empty = (cnt == 0);
        if (cnt == 0) begin
            r.value = cfg_mode[1] ? pool2d_pkg::DATA_MIN : '0;
        end else if (cfg_mode[1]) begin
            r.value = best[DW-1:0];
            r.index = best_at[XW-1:0];
        end else begin
            div = (cfg_mode == pool2d_pkg::MODE_AVG_FULL) ? ww * wh : cnt;
            q = sum / div;
            r.value = q[DW-1:0];
        end
        return r;
    endfunction

    // pixel values biased toward extremes and ties
    function automatic logic signed [DW-1:0] pick_pixel();
        case ($urandom_range(0, 9))
            0:       return {1'b0, {(DW-1){1'b1}}};
            1:       return pool2d_pkg::DATA_MIN;
            2, 3:    return DW'(int'($urandom_range(0, 4)) - 2);
            default: return DW'($urandom);
        endcase
    endfunction

    // output position, mostly one whose window touches the image
    function automatic logic [DMW-1:0] pick_out_pos(input int dim, input int step);
        int span;
        if (dim > pool2d_pkg::MAX_DIM) dim = pool2d_pkg::MAX_DIM;
        span = (step == 0) ? pool2d_pkg::MAX_DIM - 1 : (dim + step - 1) / step;
        if (span > pool2d_pkg::MAX_DIM - 1) span = pool2d_pkg::MAX_DIM - 1;
        if ($urandom_range(0, 6) == 0) return DMW'($urandom);
        return DMW'($urandom_range(0, span));
    endfunction

    task automatic push_load(input logic [DMW-1:0] col, row,
                             input logic signed [DW-1:0] pix);
        t_pixel_req req;
        req.op = pool2d_pkg::OP_LOAD;
        req.col = col;
        req.row = row;
        req.pixel = pix;
        pending_reqs.push_back(req);
        planned[{row, col}] = 1'b1;
        queued++;
    endtask

    // a compute is preceded by loads of every window pixel not yet written
    task automatic push_compute(input logic [DMW-1:0] col, row);
        int x0, x1, y0, y1, iw, x, y;
        t_pixel_req req;
        window_span(col, row, x0, x1, y0, y1, iw);
        for (x = x0; x < x1; x++)
            for (y = y0; y < y1; y++)
                if (!planned[y * pool2d_pkg::MAX_DIM + x])
                    push_load(DMW'(x), DMW'(y), pick_pixel());
        req.op = pool2d_pkg::OP_COMPUTE;
        req.col = col;
        req.row = row;
        req.pixel = DW'($urandom);
        pending_reqs.push_back(req);
        queued++;
    endtask

    task automatic cfg_write(input pool2d_pkg::t_cfg_reg idx, input logic [CDW-1:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        @(posedge i_clk);
        case (idx)
            pool2d_pkg::CFG_POOL_MODE:     cfg_mode = val[MRW-1:0];
            pool2d_pkg::CFG_WINDOW_WIDTH:  cfg_ww = val[WRW-1:0];
            pool2d_pkg::CFG_WINDOW_HEIGHT: cfg_wh = val[WRW-1:0];
            pool2d_pkg::CFG_STRIDE_X:      cfg_sx = val[WRW-1:0];
            pool2d_pkg::CFG_STRIDE_Y:      cfg_sy = val[WRW-1:0];
            pool2d_pkg::CFG_IMAGE_WIDTH:   cfg_iw = val[IRW-1:0];
            pool2d_pkg::CFG_IMAGE_HEIGHT:  cfg_ih = val[IRW-1:0];
            default: ;
        endcase
    endtask

    // wait until nothing is queued or expected, then let the block settle
    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_reqs.size() != 0 || i_in_valid || expected_pools.size() != 0);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic pick_pressure();
        case ($urandom_range(0, 3))
            0:       stall_pct = 0;
            1:       stall_pct = 20;
            2:       stall_pct = 50;
            default: stall_pct = 80;
        endcase
        case ($urandom_range(0, 2))
            0:       gap_max = 0;
            1:       gap_max = 3;
            default: gap_max = 10;
        endcase
    endtask

    // one register setting followed by a run of random transactions
    task automatic run_phase(input logic [CDW-1:0] mode, ww, wh, sx, sy, iw, ih,
                             input int n);
        int k;
        cfg_write(pool2d_pkg::CFG_POOL_MODE, mode);
        cfg_write(pool2d_pkg::CFG_WINDOW_WIDTH, ww);
        cfg_write(pool2d_pkg::CFG_WINDOW_HEIGHT, wh);
        cfg_write(pool2d_pkg::CFG_STRIDE_X, sx);
        cfg_write(pool2d_pkg::CFG_STRIDE_Y, sy);
        cfg_write(pool2d_pkg::CFG_IMAGE_WIDTH, iw);
        cfg_write(pool2d_pkg::CFG_IMAGE_HEIGHT, ih);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        pick_pressure();
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 30)
                push_load(DMW'($urandom), DMW'($urandom), pick_pixel());
            else
                push_compute(pick_out_pos(cfg_iw, cfg_sx), pick_out_pos(cfg_ih, cfg_sy));
        end
        wait_idle();
    endtask

    // input driver: bursts with random gaps, payload held while stalled
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_out_stall <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            if (!i_in_valid || in_fired) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    next_req = pending_reqs.pop_front();
                    i_in_valid <= 1'b1;
                    i_op <= next_req.op;
                    i_col <= next_req.col;
                    i_row <= next_req.row;
                    i_pixel_value <= next_req.pixel;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 16);
                        gap_left <= $urandom_range(0, gap_max);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // prediction on each input transaction, checking on each output transaction
    always @(posedge i_clk) begin
        in_fired = i_rst_n && i_in_valid && !o_in_stall;
        if (in_fired) begin
            if (i_op == pool2d_pkg::OP_LOAD) plane[{i_row, i_col}] = i_pixel_value;
            else expected_pools.push_back(pool_window(i_col, i_row));
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_pools.size() == 0) begin
                $display("%0t: unexpected result value=%0d index=%0d empty=%0b",
                         $time, o_pooled_value, o_max_index, o_empty_window);
                fail_count++;
            end else begin
                want = expected_pools.pop_front();
                if (o_pooled_value !== want.value) begin
                    $display("%0t: pooled_value expected %0d actual %0d",
                             $time, want.value, o_pooled_value);
                    fail_count++;
                end
                if (o_max_index !== want.index) begin
                    $display("%0t: max_index expected %0d actual %0d",
                             $time, want.index, o_max_index);
                    fail_count++;
                end
                if (o_empty_window !== want.empty) begin
                    $display("%0t: empty_window expected %0b actual %0b",
                             $time, want.empty, o_empty_window);
                    fail_count++;
                end
            end
        end
    end

    // main sequence
    initial begin
        int n;
        int mode, ww, wh, sx, sy, iw, ih;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset setting (max, 2x2 window, stride 2, 64x64 image)
        stall_pct = 30;
        gap_max = 3;
        // extremes with a tie on the maximum
        push_load(0, 0, {1'b0, {(DW-1){1'b1}}});
        push_load(1, 0, pool2d_pkg::DATA_MIN);
        push_load(0, 1, pool2d_pkg::DATA_MIN);
        push_load(1, 1, {1'b0, {(DW-1){1'b1}}});
        push_compute(0, 0);
        // window of minimum values keeps the first pixel
        push_load(2, 0, pool2d_pkg::DATA_MIN);
        push_load(3, 0, pool2d_pkg::DATA_MIN);
        push_load(2, 1, pool2d_pkg::DATA_MIN);
        push_load(3, 1, pool2d_pkg::DATA_MIN);
        push_compute(1, 0);
        // bottom-right corner with ties
        push_load(62, 62, 7);
        push_load(63, 62, 7);
        push_load(62, 63, 7);
        push_load(63, 63, -1);
        push_compute(31, 31);
        // window past the image edge
        push_compute(63, 63);
        push_compute(32, 5);
        wait_idle();

        // directed settings: both averages with clipping, spare mode,
        // oversized window and image, zero stride, zero dimensions, extremes
        run_phase(CDW'(pool2d_pkg::MODE_AVG_FULL),  3, 3, 3, 3, 10, 10, 20);
        run_phase(CDW'(pool2d_pkg::MODE_AVG_VALID), 3, 3, 3, 3, 10, 10, 20);
        run_phase(CDW'(MODE_SPARE),                 31, 1, 0, 1, 127, 64, 12);
        run_phase(CDW'(pool2d_pkg::MODE_AVG_FULL),  0, 5, 1, 1, 64, 64, 8);
        run_phase(CDW'(pool2d_pkg::MODE_AVG_VALID), 4, 0, 1, 1, 64, 64, 8);
        run_phase(CDW'(pool2d_pkg::MODE_MAX),       2, 2, 1, 1, 0, 64, 8);
        run_phase(CDW'(pool2d_pkg::MODE_AVG_VALID), 2, 2, 1, 1, 64, 0, 8);
        run_phase(CDW'(pool2d_pkg::MODE_AVG_FULL),  16, 16, 16, 16, 16, 16, 4);
        run_phase(CDW'(pool2d_pkg::MODE_MAX),       16, 16, 16, 16, 16, 16, 4);
        run_phase(CDW'(pool2d_pkg::MODE_AVG_VALID), 1, 1, 1, 1, 1, 1, 10);
        run_phase(CDW'(pool2d_pkg::MODE_MAX),       1, 1, 16, 16, 64, 64, 10);

        // random settings, upper data bits of narrow registers as noise
        while (queued < ITEM_TARGET) begin
            mode = $urandom_range(0, 3) + 4 * $urandom_range(0, 31);
            ww = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 5);
            wh = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 5);
            sx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16) : $urandom_range(1, 4);
            sy = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16) : $urandom_range(1, 4);
            iw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 64);
            ih = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 64);
            n = $urandom_range(30, 80);
            run_phase(CDW'(mode),
                      CDW'(ww + 32 * $urandom_range(0, 3)), CDW'(wh + 32 * $urandom_range(0, 3)),
                      CDW'(sx + 32 * $urandom_range(0, 3)), CDW'(sy + 32 * $urandom_range(0, 3)),
                      CDW'(iw), CDW'(ih), n);
        end

        repeat (300) @(posedge i_clk);
        if (fail_count == 0 && expected_pools.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // run limit
    initial begin
        #200000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[sim.f]
rtl/core/pool2d_pkg.sv
rtl/core/pool2d_ram.sv
rtl/core/pooling_2d_forward.sv
tb/sv/testbench.sv
